// ----- rtl/psc_pkg.sv -----
package psc_pkg;

    localparam int MulAW = 48;
    localparam int MulBW = 26;
    localparam int MulPW = MulAW + MulBW;
    localparam int DivW = 32;
    localparam int DivDW = 8;

    localparam logic [7:0] CFG_SENS_BASE     = 8'd0;
    localparam logic [7:0] CFG_OFFSET_BASE   = 8'd1;
    localparam logic [7:0] CFG_SENS_TEMPCO   = 8'd2;
    localparam logic [7:0] CFG_OFFSET_TEMPCO = 8'd3;
    localparam logic [7:0] CFG_REF_TEMP      = 8'd4;
    localparam logic [7:0] CFG_TEMP_COEFF    = 8'd5;
    localparam logic [7:0] CFG_VARIANT_SEL   = 8'd6;
    localparam logic [7:0] CFG_AVG_COUNT     = 8'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DT,
        ST_TEMP,
        ST_OFF,
        ST_SENS,
        ST_T2,
        ST_DL,
        ST_DLSQ,
        ST_DVSQ,
        ST_APPLY,
        ST_PMUL,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/pressure_sensor_compensation_unit.sv -----
// An accepted pair that does not complete an average is only accumulated.
// A pair that completes an average is averaged and compensated; its word becomes valid after
// a bit-serial divider, five to seven passes of a bit-serial multiplier
// and four further steps, and later still while an earlier word waits on the output.
// While a result is computed no pair is accepted; a waiting result does not block input.
// Asynchronous active-low reset clears accumulators, count, state and output valid, sets the averaging
// count register to one and the other configuration registers to zero; datapath and output word are not reset.
module pressure_sensor_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pressure_raw[23:0], temperature_raw[47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // temp_centideg[18:0], pressure_units[50:19], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] sens_base_reg, offset_base_reg, sens_tempco_reg, offset_tempco_reg;
    logic [15:0] ref_temp_reg, temp_coeff_reg;
    logic        variant_sel_reg;
    logic [7:0]  avg_count_reg;

    logic [31:0] psum_reg, tsum_reg;
    logic [7:0]  count_reg;
    logic [23:0] d1_reg, d2_reg;
    logic signed [25:0] dt_reg;
    logic signed [25:0] dl_reg;
    logic signed [31:0] temp_reg;
    logic signed [31:0] t2_reg;
    logic signed [63:0] off_reg, sens_reg, off2_reg, sens2_reg, p_reg;
    logic [18:0] out_temp_reg;
    logic [31:0] out_p_reg;
    logic        m_tvalid_reg;
    logic        launched_reg;

    psc_pkg::state_t state_reg, state_next;

    logic [7:0]  runs;
    logic [7:0]  count_inc;
    logic        two_bar;
    logic        in_accept;

    logic        mul_start, mul_done;
    logic signed [psc_pkg::MulAW-1:0] mul_a;
    logic signed [psc_pkg::MulBW-1:0] mul_b;
    logic signed [psc_pkg::MulPW-1:0] mul_p;
    logic signed [63:0] pr;

    logic        div_start, pdiv_done, tdiv_done;
    logic [31:0] pq, tq;

    logic signed [63:0] p_fin;

    function automatic logic signed [63:0] div_pow2(input logic signed [63:0] x, input int k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    assign two_bar   = variant_sel_reg;
    assign runs      = (avg_count_reg == 8'd0) ? 8'd1 : avg_count_reg;
    assign count_inc = count_reg + 8'd1;
    assign in_accept = s_tvalid && s_tready;
    assign pr        = mul_p[63:0];
    assign cfg_ready = 1'b1;

    psc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    psc_div u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (psum_reg),
        .divisor  (count_reg),
        .done     (pdiv_done),
        .quotient (pq)
    );

    psc_div u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tsum_reg),
        .divisor  (count_reg),
        .done     (tdiv_done),
        .quotient (tq)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (in_accept && (count_inc >= runs))
                begin
                    state_next = psc_pkg::ST_DIV;
                end
            end
            psc_pkg::ST_DIV:   if (pdiv_done && tdiv_done) state_next = psc_pkg::ST_DT;
            psc_pkg::ST_DT:    state_next = psc_pkg::ST_TEMP;
            psc_pkg::ST_TEMP:  if (mul_done) state_next = psc_pkg::ST_OFF;
            psc_pkg::ST_OFF:   if (mul_done) state_next = psc_pkg::ST_SENS;
            psc_pkg::ST_SENS:  if (mul_done) state_next = psc_pkg::ST_T2;
            psc_pkg::ST_T2:    if (mul_done) state_next = psc_pkg::ST_DL;
            psc_pkg::ST_DL:
            begin
                state_next = (temp_reg < 32'sd2000) ? psc_pkg::ST_DLSQ : psc_pkg::ST_APPLY;
            end
            psc_pkg::ST_DLSQ:
            begin
                if (mul_done)
                begin
                    state_next = (temp_reg < -32'sd1500) ? psc_pkg::ST_DVSQ
                                                        : psc_pkg::ST_APPLY;
                end
            end
            psc_pkg::ST_DVSQ:  if (mul_done) state_next = psc_pkg::ST_APPLY;
            psc_pkg::ST_APPLY: state_next = psc_pkg::ST_PMUL;
            psc_pkg::ST_PMUL:  if (mul_done) state_next = psc_pkg::ST_OUT;
            psc_pkg::ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = psc_pkg::ST_IDLE;
            default:           state_next = psc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == psc_pkg::ST_IDLE);
        div_start = (state_reg == psc_pkg::ST_DIV) && !launched_reg;
        mul_start = 1'b0;
        mul_a     = psc_pkg::MulAW'(dt_reg);
        mul_b     = dt_reg;
        case (state_reg)
            psc_pkg::ST_TEMP:
            begin
                mul_start = !launched_reg;
                mul_b     = $signed({10'd0, temp_coeff_reg});
            end
            psc_pkg::ST_OFF:
            begin
                mul_start = !launched_reg;
                mul_b     = $signed({10'd0, offset_tempco_reg});
            end
            psc_pkg::ST_SENS:
            begin
                mul_start = !launched_reg;
                mul_b     = $signed({10'd0, sens_tempco_reg});
            end
            psc_pkg::ST_T2:
            begin
                mul_start = !launched_reg;
            end
            psc_pkg::ST_DLSQ, psc_pkg::ST_DVSQ:
            begin
                mul_start = !launched_reg;
                mul_a     = psc_pkg::MulAW'(dl_reg);
                mul_b     = dl_reg;
            end
            psc_pkg::ST_PMUL:
            begin
                mul_start = !launched_reg;
                mul_a     = sens_reg[psc_pkg::MulAW-1:0];
                mul_b     = $signed({2'd0, d1_reg});
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign p_fin = div_pow2(p_reg, two_bar ? 15 : 13);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= psc_pkg::ST_IDLE;
            launched_reg      <= 1'b0;
            sens_base_reg     <= '0;
            offset_base_reg   <= '0;
            sens_tempco_reg   <= '0;
            offset_tempco_reg <= '0;
            ref_temp_reg      <= '0;
            temp_coeff_reg    <= '0;
            variant_sel_reg   <= 1'b0;
            avg_count_reg     <= 8'd1;
            psum_reg          <= '0;
            tsum_reg          <= '0;
            count_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= (state_next == state_reg) ? (launched_reg | mul_start | div_start)
                                                      : 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    psc_pkg::CFG_SENS_BASE:     sens_base_reg     <= cfg_data;
                    psc_pkg::CFG_OFFSET_BASE:   offset_base_reg   <= cfg_data;
                    psc_pkg::CFG_SENS_TEMPCO:   sens_tempco_reg   <= cfg_data;
                    psc_pkg::CFG_OFFSET_TEMPCO: offset_tempco_reg <= cfg_data;
                    psc_pkg::CFG_REF_TEMP:      ref_temp_reg      <= cfg_data;
                    psc_pkg::CFG_TEMP_COEFF:    temp_coeff_reg    <= cfg_data;
                    psc_pkg::CFG_VARIANT_SEL:   variant_sel_reg   <= cfg_data[0];
                    psc_pkg::CFG_AVG_COUNT:     avg_count_reg     <= cfg_data[7:0];
                    default:                    ;
                endcase
            end
            if (in_accept)
            begin
                psum_reg  <= psum_reg + {8'd0, s_tdata[23:0]};
                tsum_reg  <= tsum_reg + {8'd0, s_tdata[47:24]};
                count_reg <= count_inc;
            end
            if ((state_reg == psc_pkg::ST_DIV) && pdiv_done && tdiv_done)
            begin
                psum_reg  <= '0;
                tsum_reg  <= '0;
                count_reg <= '0;
            end
            if ((state_reg == psc_pkg::ST_OUT) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            psc_pkg::ST_DIV:
            begin
                d1_reg <= pq[23:0];
                d2_reg <= tq[23:0];
            end
            psc_pkg::ST_DT:
            begin
                dt_reg <= $signed({2'd0, d2_reg}) - $signed({2'd0, ref_temp_reg, 8'd0});
            end
            psc_pkg::ST_TEMP:
            begin
                temp_reg <= 32'sd2000 + 32'(div_pow2(pr, 23));
            end
            psc_pkg::ST_OFF:
            begin
                off_reg <= two_bar
                    ? ($signed({48'd0, offset_base_reg}) <<< 17) + (pr >>> 6)
                    : ($signed({48'd0, offset_base_reg}) <<< 16) + (pr >>> 7);
            end
            psc_pkg::ST_SENS:
            begin
                sens_reg <= two_bar
                    ? ($signed({48'd0, sens_base_reg}) <<< 16) + (pr >>> 7)
                    : ($signed({48'd0, sens_base_reg}) <<< 15) + (pr >>> 8);
            end
            psc_pkg::ST_T2:
            begin
                t2_reg <= two_bar
                    ? 32'(((pr <<< 3) + (pr <<< 1) + pr) >>> 35)
                    : 32'(((pr <<< 1) + pr) >>> 33);
            end
            psc_pkg::ST_DL:
            begin
                dl_reg    <= 26'(temp_reg - 32'sd2000);
                off2_reg  <= '0;
                sens2_reg <= '0;
                if (temp_reg >= 32'sd2000)
                begin
                    t2_reg <= '0;
                end
            end
            psc_pkg::ST_DLSQ:
            begin
                dl_reg <= 26'(temp_reg + 32'sd1500);
                if (two_bar)
                begin
                    off2_reg  <= ((pr <<< 5) - pr) >>> 3;
                    sens2_reg <= ((pr <<< 6) - pr) >>> 5;
                end
                else
                begin
                    off2_reg  <= ((pr <<< 1) + pr) >>> 1;
                    sens2_reg <= ((pr <<< 2) + pr) >>> 3;
                end
            end
            psc_pkg::ST_DVSQ:
            begin
                if (mul_done)
                begin
                    off2_reg  <= off2_reg + ((pr <<< 3) - pr);
                    sens2_reg <= sens2_reg + (pr <<< 2);
                end
            end
            psc_pkg::ST_APPLY:
            begin
                temp_reg <= temp_reg - t2_reg;
                off_reg  <= off_reg - off2_reg;
                sens_reg <= sens_reg - sens2_reg;
            end
            psc_pkg::ST_PMUL:
            begin
                p_reg <= div_pow2(pr, 21) - off_reg;
            end
            psc_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    if (temp_reg > 32'sd262143)
                        out_temp_reg <= 19'h3FFFF;
                    else if (temp_reg < -32'sd262144)
                        out_temp_reg <= 19'h40000;
                    else
                        out_temp_reg <= temp_reg[18:0];
                    if (p_fin > 64'sd2147483647)
                        out_p_reg <= 32'h7FFFFFFF;
                    else if (p_fin < -64'sd2147483648)
                        out_p_reg <= 32'h80000000;
                    else
                        out_p_reg <= p_fin[31:0];
                end
            end
            default:
            begin
                d1_reg <= d1_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_p_reg, out_temp_reg};

endmodule

// ----- rtl/psc_mul.sv -----
module psc_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [psc_pkg::MulAW-1:0]    a,
    input  logic signed [psc_pkg::MulBW-1:0]    b,
    output logic                                done,
    output logic signed [psc_pkg::MulPW-1:0]    product
);

    localparam int CntW = $clog2(psc_pkg::MulBW);

    logic signed [psc_pkg::MulPW-1:0] acc_reg, acc_next;
    logic signed [psc_pkg::MulPW-1:0] ash_reg, ash_next;
    logic [psc_pkg::MulBW-1:0]        b_reg, b_next;
    logic [CntW-1:0]                  cnt_reg, cnt_next;
    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    logic                             last;

    assign last = (cnt_reg == CntW'(psc_pkg::MulBW - 1));

    always_comb
    begin
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            ash_next = psc_pkg::MulPW'(a);
            b_next   = b;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // The top bit of the multiplier carries negative weight.
            if (b_reg[0])
            begin
                acc_next = last ? acc_reg - ash_reg : acc_reg + ash_reg;
            end
            ash_next = ash_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/psc_div.sv -----
module psc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psc_pkg::DivW-1:0]    dividend,
    input  logic [psc_pkg::DivDW-1:0]   divisor,
    output logic                        done,
    output logic [psc_pkg::DivW-1:0]    quotient
);

    localparam int CntW = $clog2(psc_pkg::DivW);

    logic [psc_pkg::DivDW-1:0] rem_reg, rem_next;
    logic [psc_pkg::DivDW-1:0] d_reg, d_next;
    logic [psc_pkg::DivW-1:0]  q_reg, q_next;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [psc_pkg::DivDW:0]   shifted;
    logic                      fits;

    assign shifted = {rem_reg, q_reg[psc_pkg::DivW-1]};
    assign fits    = (shifted >= {1'b0, d_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            d_next   = divisor;
            q_next   = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? psc_pkg::DivDW'(shifted - {1'b0, d_reg})
                            : shifted[psc_pkg::DivDW-1:0];
            q_next   = {q_reg[psc_pkg::DivW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(psc_pkg::DivW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
